>>> hw/rtl/dvru_pkg.sv
package dvru_pkg;

	localparam int MAX_NODES = 16;
	localparam int NODE_BITS = $clog2(MAX_NODES);
	localparam int COST_BITS = 16;
	localparam int ENTRY_W   = COST_BITS + 1;
	localparam int CNT_BITS  = NODE_BITS + 1;
	localparam int ADDR_BITS = 2 * NODE_BITS;
	localparam int CFG_W     = CNT_BITS;

	localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};
	localparam logic [ENTRY_W-1:0] ENTRY_UNREACH = {1'b1, {COST_BITS{1'b0}}};
	localparam logic [ENTRY_W-1:0] ENTRY_ZERO = '0;

	localparam logic CFG_SELF_ID    = 1'b0;
	localparam logic CFG_NODE_COUNT = 1'b1;

	localparam logic REQ_LINK   = 1'b0;
	localparam logic REQ_VECTOR = 1'b1;

	typedef struct packed {
		logic                 req_type;
		logic [NODE_BITS-1:0] neighbor;
		logic [NODE_BITS-1:0] destination;
		logic [COST_BITS-1:0] cost;
		logic                 unreachable;
		logic                 last;
	} in_item_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] route_dest;
		logic [COST_BITS-1:0] route_cost;
		logic                 route_unreachable;
		logic [NODE_BITS-1:0] next_hop;
		logic                 vector_changed;
		logic                 last_route;
	} out_item_t;

	typedef enum logic {
		CMD_LINK,
		CMD_VECTOR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic                 wr_en;
		logic                 recompute;
		logic [NODE_BITS-1:0] neighbor;
		logic [NODE_BITS-1:0] destination;
		logic [ENTRY_W-1:0]   entry;
	} cmd_t;

endpackage

>>> hw/rtl/dvru_front.sv
module dvru_front import dvru_pkg::*; (
	input  in_item_t             item,
	input  logic [NODE_BITS-1:0] self_id,
	output cmd_t                 cmd
);

	always_comb begin
		cmd.kind        = (item.req_type == REQ_VECTOR) ? CMD_VECTOR : CMD_LINK;
		// Writes that name this router as neighbour are dropped; the own row
		// belongs to the engine.
		cmd.wr_en       = (item.neighbor != self_id);
		cmd.recompute   = (item.req_type == REQ_VECTOR) && item.last;
		cmd.neighbor    = item.neighbor;
		cmd.destination = item.destination;
		cmd.entry       = item.unreachable ? ENTRY_UNREACH : {1'b0, item.cost};
	end

endmodule

>>> hw/rtl/dvru_queue.sv
module dvru_queue import dvru_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output cmd_t pop_cmd
);

	cmd_t       slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_cmd   = slot_q[rptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wptr_q <= ~wptr_q;
			if (do_pop) rptr_q <= ~rptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wptr_q] <= push_cmd;
	end

endmodule

>>> hw/rtl/dvru_back.sv
module dvru_back import dvru_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [NODE_BITS-1:0] self_id,
	input  logic [CNT_BITS-1:0]  node_count,
	input  logic                 cmd_valid,
	input  cmd_t                 cmd,
	output logic                 cmd_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item
);

	typedef enum logic [2:0] {
		B_IDLE,
		B_RC_START,
		B_RC_CUR,
		B_RC_NB,
		B_RC_EVAL,
		B_RC_WR,
		B_EM_RD,
		B_EM_OUT
	} state_t;

	localparam int DEPTH = MAX_NODES * MAX_NODES;

	state_t               state_q;
	logic [NODE_BITS-1:0] d_q;
	logic [NODE_BITS-1:0] j_q;
	logic [ENTRY_W-1:0]   cur_q;
	logic [NODE_BITS-1:0] hop_q;
	logic                 changed_q;
	logic [ENTRY_W-1:0]   link_q [MAX_NODES];
	logic [NODE_BITS-1:0] hop_row_q [MAX_NODES];
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [ENTRY_W-1:0]   mem [DEPTH];
	logic [DEPTH-1:0]     valid_q;
	logic [ENTRY_W-1:0]   rdata_q;
	logic                 rvalid_q;
	logic                 rdiag_q;

	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_waddr;
	logic [ENTRY_W-1:0]   mem_wdata;
	logic                 mem_re;
	logic [ADDR_BITS-1:0] mem_raddr;
	logic [ENTRY_W-1:0]   rd_entry;

	logic [CNT_BITS-1:0]  n_eff;
	logic [NODE_BITS-1:0] last_idx;
	logic [ENTRY_W-1:0]   lc;
	logic [COST_BITS:0]   sum;
	logic [ENTRY_W-1:0]   cand;
	logic                 cand_ok;
	logic                 out_free;

	always_comb begin
		if (node_count == '0) n_eff = CNT_BITS'(1);
		else if (node_count > CNT_BITS'(MAX_NODES)) n_eff = CNT_BITS'(MAX_NODES);
		else n_eff = node_count;
	end
	assign last_idx = NODE_BITS'(n_eff - CNT_BITS'(1));

	// Entries never written hold their reset value: zero on the diagonal.
	assign rd_entry = rvalid_q ? rdata_q : (rdiag_q ? ENTRY_ZERO : ENTRY_UNREACH);

	assign lc      = link_q[j_q];
	assign sum     = {1'b0, lc[COST_BITS-1:0]} + {1'b0, rd_entry[COST_BITS-1:0]};
	assign cand    = {1'b0, sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0]};
	assign cand_ok = !lc[COST_BITS] && !rd_entry[COST_BITS];

	assign out_free  = !out_valid_q || !out_stall;
	assign cmd_pop   = (state_q == B_IDLE) && cmd_valid;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = cmd.entry;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid && cmd.wr_en) begin
					mem_we = 1'b1;
					mem_waddr = (cmd.kind == CMD_LINK) ? {self_id, cmd.neighbor}
						: {cmd.neighbor, cmd.destination};
				end
			end
			B_RC_START: begin
				mem_re    = (d_q != self_id);
				mem_raddr = {self_id, d_q};
			end
			B_RC_NB: begin
				mem_re    = (j_q != self_id);
				mem_raddr = {j_q, d_q};
			end
			B_RC_WR: begin
				mem_we    = 1'b1;
				mem_waddr = {self_id, d_q};
				mem_wdata = cur_q;
			end
			B_EM_RD: begin
				mem_re    = 1'b1;
				mem_raddr = {self_id, d_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
			rdiag_q <= (mem_raddr[ADDR_BITS-1:NODE_BITS] == mem_raddr[NODE_BITS-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (mem_we) valid_q[mem_waddr] <= 1'b1;
			if (mem_re) rvalid_q <= valid_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			d_q         <= '0;
			j_q         <= '0;
			cur_q       <= '0;
			hop_q       <= '0;
			changed_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < MAX_NODES; i++) begin
				link_q[i]    <= ENTRY_UNREACH;
				hop_row_q[i] <= NODE_BITS'(i);
			end
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						if (cmd.kind == CMD_LINK && cmd.wr_en) begin
							link_q[cmd.neighbor]    <= cmd.entry;
							hop_row_q[cmd.neighbor] <= cmd.neighbor;
						end
						if (cmd.recompute) begin
							d_q       <= '0;
							changed_q <= 1'b0;
							state_q   <= B_RC_START;
						end
					end
				end
				B_RC_START: begin
					if (d_q != self_id) begin
						state_q <= B_RC_CUR;
					end else if (d_q == last_idx) begin
						d_q     <= '0;
						state_q <= B_EM_RD;
					end else begin
						d_q <= d_q + NODE_BITS'(1);
					end
				end
				B_RC_CUR: begin
					cur_q   <= rd_entry;
					hop_q   <= hop_row_q[d_q];
					j_q     <= '0;
					state_q <= B_RC_NB;
				end
				B_RC_NB: begin
					if (j_q != self_id) begin
						state_q <= B_RC_EVAL;
					end else if (j_q == last_idx) begin
						state_q <= B_RC_WR;
					end else begin
						j_q <= j_q + NODE_BITS'(1);
					end
				end
				B_RC_EVAL: begin
					if (cand_ok) begin
						if (cur_q[COST_BITS] || cand < cur_q) begin
							cur_q     <= cand;
							hop_q     <= j_q;
							changed_q <= 1'b1;
						end else if (cand == cur_q && j_q < hop_q) begin
							hop_q <= j_q;
						end
					end
					if (j_q == last_idx) begin
						state_q <= B_RC_WR;
					end else begin
						j_q     <= j_q + NODE_BITS'(1);
						state_q <= B_RC_NB;
					end
				end
				B_RC_WR: begin
					hop_row_q[d_q] <= hop_q;
					if (d_q == last_idx) begin
						d_q     <= '0;
						state_q <= B_EM_RD;
					end else begin
						d_q     <= d_q + NODE_BITS'(1);
						state_q <= B_RC_START;
					end
				end
				B_EM_RD: begin
					state_q <= B_EM_OUT;
				end
				B_EM_OUT: begin
					if (out_free) begin
						out_valid_q             <= 1'b1;
						out_q.route_dest        <= d_q;
						out_q.route_cost        <= rd_entry[COST_BITS] ? '0
							: rd_entry[COST_BITS-1:0];
						out_q.route_unreachable <= rd_entry[COST_BITS];
						out_q.next_hop          <= hop_row_q[d_q];
						out_q.vector_changed    <= changed_q;
						out_q.last_route        <= (d_q == last_idx);
						if (d_q == last_idx) begin
							state_q <= B_IDLE;
						end else begin
							d_q     <= d_q + NODE_BITS'(1);
							state_q <= B_EM_RD;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("table read and write in the same cycle");

	a_own_row_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RC_WR) |-> (mem_waddr[ADDR_BITS-1:NODE_BITS] == self_id))
		else $error("recomputed entry written outside own row");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EM_OUT && out_free && d_q == last_idx) |=>
		(state_q == B_IDLE && out_valid_q && out_q.last_route))
		else $error("final route beat did not return engine to idle");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled route beat dropped");
`endif

endmodule

>>> hw/rtl/distance_vector_route_update.sv
// Distance-vector route engine for one router.
// Input channel (in_valid/in_stall, in_item): a beat is taken when in_valid
// is high and in_stall low. Link beats set a neighbour's link cost; vector
// beats store one advertised distance. A vector beat with last set starts a
// recomputation of the own row and then emits one route beat per node, for
// node_count clamped to 1..16, on the output channel (out_valid/out_stall,
// out_item), destination 0 first, last_route marking the final one.
// Link and plain vector beats leave the engine idle; a two-entry command queue
// sits in front of the engine, so in_stall rises only when it is full.
// A recomputation reads the distance table once per (destination, neighbour)
// pair through its single read port, then emits the route beats, each after
// its own table read. Output stall holds the current route beat and pauses
// the engine, which keeps the queue filling until it is full.
// Reset restores the table diagonal to zero and all other distances and
// link costs to unreachable, next hops to their own index, self_id to 0 and
// node_count to 16. The user must write configuration through cfg_we/
// cfg_index/cfg_wdata only while the engine is idle; the block itself does
// not enforce this.
module distance_vector_route_update import dvru_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic [NODE_BITS-1:0] self_id_q;
	logic [CNT_BITS-1:0]  node_count_q;
	cmd_t                 front_cmd;
	cmd_t                 back_cmd;
	logic                 q_full;
	logic                 q_valid;
	logic                 q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q    <= '0;
			node_count_q <= CNT_BITS'(MAX_NODES);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SELF_ID:    self_id_q    <= cfg_wdata[NODE_BITS-1:0];
				CFG_NODE_COUNT: node_count_q <= cfg_wdata[CNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = q_full;

	dvru_front u_front (
		.item    (in_item),
		.self_id (self_id_q),
		.cmd     (front_cmd)
	);

	dvru_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_cmd  (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_cmd   (back_cmd)
	);

	dvru_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.self_id    (self_id_q),
		.node_count (node_count_q),
		.cmd_valid  (q_valid),
		.cmd        (back_cmd),
		.cmd_pop    (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule

>>> bench/distance_vector_route_update_tb.sv
module distance_vector_route_update_tb;
	import dvru_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	distance_vector_route_update dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Routing state as the block should hold it. Bit COST_BITS of an entry marks
	// the entry as unreachable.
	logic [ENTRY_W-1:0] dist_tbl [MAX_NODES][MAX_NODES];
	logic [ENTRY_W-1:0] link_cost [MAX_NODES];
	logic [NODE_BITS-1:0] hop_row [MAX_NODES];
	logic [NODE_BITS-1:0] my_id;
	logic [CNT_BITS-1:0] n_nodes;

	in_item_t pending_beats[$];
	out_item_t route_queue[$];
	int sender_idle_pct;
	int receiver_idle_pct;
	int quiet_cycles;
	bit failed;
	bit done;
	// Set at the rising edge that took the current input beat.
	bit in_fire;

	localparam int WATCHDOG_LIMIT = 20000;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic reset_routes();
		for (int i = 0; i < MAX_NODES; i++) begin
			for (int j = 0; j < MAX_NODES; j++)
				dist_tbl[i][j] = (i == j) ? ENTRY_ZERO : ENTRY_UNREACH;
			link_cost[i] = ENTRY_UNREACH;
			hop_row[i] = NODE_BITS'(i);
		end
		my_id = '0;
		n_nodes = CNT_BITS'(MAX_NODES);
	endtask

	task automatic predict_routes(input in_item_t it);
		logic [ENTRY_W-1:0] ent;
		logic [ENTRY_W-1:0] cur;
		logic [ENTRY_W-1:0] lc;
		logic [ENTRY_W-1:0] nd;
		logic [ENTRY_W:0] sum;
		logic [NODE_BITS-1:0] hop;
		logic [ENTRY_W-1:0] e;
		out_item_t r;
		int n;
		bit changed;
		ent = it.unreachable ? ENTRY_UNREACH : {1'b0, it.cost};
		changed = 1'b0;
		if (it.req_type == REQ_LINK) begin
			if (it.neighbor != my_id) begin
				link_cost[it.neighbor] = ent;
				dist_tbl[my_id][it.neighbor] = ent;
				hop_row[it.neighbor] = it.neighbor;
			end
			return;
		end
		if (it.neighbor != my_id)
			dist_tbl[it.neighbor][it.destination] = ent;
		if (!it.last)
			return;
		n = (n_nodes == 0) ? 1 : (n_nodes > MAX_NODES ? MAX_NODES : int'(n_nodes));
		for (int d = 0; d < n; d++) begin
			if (d == my_id)
				continue;
			cur = dist_tbl[my_id][d];
			hop = hop_row[d];
			for (int j = 0; j < n; j++) begin
				if (j == my_id)
					continue;
				lc = link_cost[j];
				nd = dist_tbl[j][d];
				if (lc[COST_BITS] || nd[COST_BITS])
					continue;
				sum = lc + nd;
				if (sum > COST_MAX)
					sum = COST_MAX;
				if (cur[COST_BITS] || sum < cur) begin
					cur = sum[ENTRY_W-1:0];
					hop = NODE_BITS'(j);
					changed = 1'b1;
				end else if (sum == cur && j < hop) begin
					hop = NODE_BITS'(j);
				end
			end
			dist_tbl[my_id][d] = cur;
			hop_row[d] = hop;
		end
		for (int d = 0; d < n; d++) begin
			e = dist_tbl[my_id][d];
			r.route_dest = NODE_BITS'(d);
			r.route_cost = e[COST_BITS] ? '0 : e[COST_BITS-1:0];
			r.route_unreachable = e[COST_BITS];
			r.next_hop = hop_row[d];
			r.vector_changed = changed;
			r.last_route = (d + 1 == n);
			route_queue.push_back(r);
		end
	endtask

	function automatic in_item_t rand_beat(input bit vec, input bit last);
		in_item_t it;
		it.req_type = vec ? REQ_VECTOR : REQ_LINK;
		it.neighbor = NODE_BITS'($urandom_range(0, MAX_NODES - 1));
		it.destination = NODE_BITS'($urandom_range(0, MAX_NODES - 1));
		case ($urandom_range(0, 5))
			0: it.cost = COST_MAX - COST_BITS'($urandom_range(0, 3));
			1: it.cost = COST_BITS'($urandom);
			default: it.cost = COST_BITS'($urandom_range(0, 40));
		endcase
		it.unreachable = ($urandom_range(0, 7) == 0);
		it.last = last;
		return it;
	endfunction

	function automatic in_item_t mk(input logic rt, input int nb, input int dst,
			input int c, input bit unr, input bit last);
		in_item_t it;
		it.req_type = rt;
		it.neighbor = NODE_BITS'(nb);
		it.destination = NODE_BITS'(dst);
		it.cost = COST_BITS'(c);
		it.unreachable = unr;
		it.last = last;
		return it;
	endfunction

	task automatic write_reg(input logic idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(val);
		if (idx == CFG_SELF_ID)
			my_id = NODE_BITS'(val);
		else
			n_nodes = CNT_BITS'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_beats.size() == 0 && !in_valid && route_queue.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// One full advertisement: link costs, then random vector beats closed by last.
	task automatic queue_round(input int n);
		int k;
		k = $urandom_range(0, 3);
		for (int i = 0; i < k; i++)
			pending_beats.push_back(rand_beat(1'b0, 1'b0));
		k = $urandom_range(0, n);
		for (int i = 0; i < k; i++)
			pending_beats.push_back(rand_beat(1'b1, 1'b0));
		pending_beats.push_back(rand_beat(1'b1, 1'b1));
	endtask

	// Driver: pops the next beat when the current one is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (pending_beats.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					in_item <= pending_beats.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
		end
	end

	// Monitor: predicts on input beats and checks output beats.
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n) begin
			in_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				predict_routes(in_item);
			if (out_valid && !out_stall) begin
				if (route_queue.size() == 0) begin
					$error("route beat with nothing expected: %p", out_item);
					failed = 1'b1;
				end else begin
					exp_r = route_queue.pop_front();
					if (out_item.route_dest !== exp_r.route_dest) begin
						$error("route_dest exp %0d got %0d", exp_r.route_dest, out_item.route_dest);
						failed = 1'b1;
					end
					if (out_item.route_cost !== exp_r.route_cost) begin
						$error("route_cost exp %0d got %0d", exp_r.route_cost, out_item.route_cost);
						failed = 1'b1;
					end
					if (out_item.route_unreachable !== exp_r.route_unreachable) begin
						$error("route_unreachable exp %0b got %0b",
							exp_r.route_unreachable, out_item.route_unreachable);
						failed = 1'b1;
					end
					if (out_item.next_hop !== exp_r.next_hop) begin
						$error("next_hop exp %0d got %0d", exp_r.next_hop, out_item.next_hop);
						failed = 1'b1;
					end
					if (out_item.vector_changed !== exp_r.vector_changed) begin
						$error("vector_changed exp %0b got %0b",
							exp_r.vector_changed, out_item.vector_changed);
						failed = 1'b1;
					end
					if (out_item.last_route !== exp_r.last_route) begin
						$error("last_route exp %0b got %0b", exp_r.last_route, out_item.last_route);
						failed = 1'b1;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > WATCHDOG_LIMIT && !done) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SELF_ID;
		cfg_wdata = '0;
		sender_idle_pct = 13;
		receiver_idle_pct = 60;
		quiet_cycles = 0;
		failed = 1'b0;
		done = 1'b0;
		reset_routes();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: recompute from reset, extreme costs, saturation, ties,
		// writes naming this router, last on a link beat.
		pending_beats.push_back(mk(REQ_VECTOR, 1, 2, 0, 0, 1));
		pending_beats.push_back(mk(REQ_LINK, 1, 0, 0, 0, 1));
		pending_beats.push_back(mk(REQ_LINK, 2, 0, 65535, 0, 0));
		pending_beats.push_back(mk(REQ_LINK, 3, 0, 5, 0, 0));
		pending_beats.push_back(mk(REQ_LINK, 4, 0, 5, 0, 0));
		pending_beats.push_back(mk(REQ_VECTOR, 2, 5, 65535, 0, 0));
		pending_beats.push_back(mk(REQ_VECTOR, 3, 6, 10, 0, 0));
		pending_beats.push_back(mk(REQ_VECTOR, 4, 6, 10, 0, 0));
		pending_beats.push_back(mk(REQ_VECTOR, 0, 7, 1, 0, 0));
		pending_beats.push_back(mk(REQ_LINK, 0, 0, 9, 0, 0));
		pending_beats.push_back(mk(REQ_VECTOR, 15, 15, 3, 1, 1));
		pending_beats.push_back(mk(REQ_VECTOR, 1, 6, 9, 0, 1));
		pending_beats.push_back(mk(REQ_LINK, 3, 0, 0, 1, 0));
		pending_beats.push_back(mk(REQ_VECTOR, 0, 0, 0, 0, 1));
		drain();

		write_reg(CFG_NODE_COUNT, 0);
		write_reg(CFG_SELF_ID, 15);
		pending_beats.push_back(mk(REQ_VECTOR, 0, 0, 7, 0, 1));
		pending_beats.push_back(mk(REQ_LINK, 15, 15, 2, 0, 0));
		pending_beats.push_back(mk(REQ_VECTOR, 14, 3, 65535, 0, 1));
		drain();
		write_reg(CFG_NODE_COUNT, 31);
		pending_beats.push_back(mk(REQ_VECTOR, 2, 3, 4, 0, 1));
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 13 : (phase == 1 ? 60 : 0);
			receiver_idle_pct = (phase == 0) ? 60 : (phase == 1 ? 13 : 0);
			for (int s = 0; s < 4; s++) begin
				write_reg(CFG_SELF_ID, $urandom_range(0, 15));
				write_reg(CFG_NODE_COUNT, (s == 0) ? 16 : ((s == 1) ? 1 : $urandom_range(2, 8)));
				for (int r = 0; r < 4; r++) begin
					queue_round(6);
					// Let the engine go empty once per setting.
					if (r == 2)
						wait (pending_beats.size() == 0 && !in_valid
							&& route_queue.size() == 0);
				end
				drain();
			end
		end

		drain();
		done = 1'b1;
		if (!failed)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/dvru_pkg.sv
hw/rtl/dvru_front.sv
hw/rtl/dvru_queue.sv
hw/rtl/dvru_back.sv
hw/rtl/distance_vector_route_update.sv
bench/distance_vector_route_update_tb.sv
